/* rtl/tasms_pkg.sv */
// Shared types, constants and helpers for the three-axis stepper move sequencer.
package tasms_pkg;

  localparam int AXES           = 3;
  localparam int FREQ_FRAC_BITS = 8;

  localparam int AXIS_FIELD_W = 2;
  localparam int AXIS_IDX_W   = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int FREQ_W       = 24;
  localparam int DUR_W        = 16;
  localparam int PROD_W       = FREQ_W + DUR_W;
  localparam int STEPS_W      = 32;
  localparam int PHASE_W      = 3;
  localparam int COIL_W       = 4;
  localparam int DONE_W       = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_IDLE = 3'd7;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd3;
  localparam logic [DONE_W-1:0]  DONE_MAX   = 8'hFF;

  typedef struct packed {
    logic                    op;
    logic [AXIS_FIELD_W-1:0] axis;
    logic                    direction;
    logic [FREQ_W-1:0]       move_frequency;
    logic [DUR_W-1:0]        move_duration;
  } in_req_t;

  typedef struct packed {
    logic [AXIS_FIELD_W-1:0] axis_out;
    logic [COIL_W-1:0]       coils;
    logic                    coils_driven;
    logic                    move_finished;
    logic [DONE_W-1:0]       finished_count;
  } out_res_t;

  // Wrap to phase zero from the last phase or from the idle marker.
  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
    next_phase = (ph >= PHASE_LAST) ? '0 : ph + 3'd1;
  endfunction

endpackage

/* rtl/tasms_step_count.sv */
// Step count of a move: floor(duration * frequency), saturated to 32 bits.
module tasms_step_count (
  input  logic [tasms_pkg::FREQ_W-1:0]  freq,
  input  logic [tasms_pkg::DUR_W-1:0]   dur,
  output logic [tasms_pkg::STEPS_W-1:0] count,
  output logic                          count_zero
);
  import tasms_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] whole;

  assign prod  = PROD_W'(dur) * PROD_W'(freq);
  assign whole = prod >> FREQ_FRAC_BITS;

  always_comb begin
    if (|whole[PROD_W-1:STEPS_W]) begin
      count = '1;
    end else begin
      count = whole[STEPS_W-1:0];
    end
  end

  // A zero frequency always gives a zero product, so one test covers both.
  assign count_zero = (count == '0);

endmodule

/* rtl/three_axis_stepper_move_sequencer.sv */
// Top level of the three-axis four-phase wave-drive stepper move sequencer.
// Each request either loads a move for one axis (direction, Q16.8 step rate and
// duration, giving floor(duration*rate) steps) or ticks one axis, and every
// request gives exactly one result. A tick on an axis with steps left advances
// that direction's phase counter and shows a one-cold, active-low coil pattern
// (counterclockwise runs the coils in reverse order); a tick with no steps left
// shows all coils low and, once per move, counts the move as finished. A load
// with a zero count finishes the move at once. finished_count is a global
// saturating total. Rate: one request per cycle sustained while out_ready
// holds; a request passes from the input register to the result register,
// which holds its result until it is taken. The 16x24 step-count multiply
// on the load path sets the critical path. Requests
// for an axis out of range change nothing and report the current total. Both
// channels stall cleanly in either direction.
module three_axis_stepper_move_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tasms_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tasms_pkg::out_res_t out_data
);
  import tasms_pkg::*;

  // Input register stage
  logic    in_valid_r;
  in_req_t in_data_r;

  // Result register stage
  logic     out_valid_r;
  out_res_t out_data_r;

  // Per-axis move state
  logic [STEPS_W-1:0] steps_r  [AXES];
  logic               dir_r    [AXES];
  logic [PHASE_W-1:0] cw_ph_r  [AXES];
  logic [PHASE_W-1:0] ccw_ph_r [AXES];
  logic               fin_r    [AXES];
  logic [DONE_W-1:0]  done_r;

  logic advance;
  logic in_range;
  logic [AXIS_IDX_W-1:0] sel;

  logic [STEPS_W-1:0] load_count;
  logic               load_zero;

  logic [STEPS_W-1:0] steps_nxt;
  logic               dir_nxt;
  logic [PHASE_W-1:0] cw_ph_nxt;
  logic [PHASE_W-1:0] ccw_ph_nxt;
  logic               fin_nxt;
  logic [DONE_W-1:0]  done_nxt;
  out_res_t           res_nxt;

  logic [1:0] low_coil;

  // Move the held request on whenever the result register is free or being drained.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sel      = AXIS_IDX_W'(in_data_r.axis);
  assign in_range = (32'(in_data_r.axis) < AXES);

  tasms_step_count u_step_count (
    .freq       (in_data_r.move_frequency),
    .dur        (in_data_r.move_duration),
    .count      (load_count),
    .count_zero (load_zero)
  );

  always_comb begin
    steps_nxt  = steps_r[sel];
    dir_nxt    = dir_r[sel];
    cw_ph_nxt  = cw_ph_r[sel];
    ccw_ph_nxt = ccw_ph_r[sel];
    fin_nxt    = fin_r[sel];
    done_nxt   = done_r;
    low_coil   = '0;

    res_nxt                = '0;
    res_nxt.axis_out       = in_data_r.axis;

    if (in_range) begin
      if (in_data_r.op == OP_LOAD) begin
        dir_nxt = in_data_r.direction;
        if (load_zero) begin
          // Nothing to step: finish the move right away.
          steps_nxt             = '0;
          fin_nxt               = 1'b1;
          res_nxt.move_finished = 1'b1;
          if (done_r != DONE_MAX) begin
            done_nxt = done_r + 8'd1;
          end
        end else begin
          steps_nxt = load_count;
          fin_nxt   = 1'b0;
        end
      end else begin
        res_nxt.coils_driven = 1'b1;
        if (steps_r[sel] != '0) begin
          // Advance only the phase counter of the move's own direction.
          if (dir_r[sel] == DIR_CW) begin
            cw_ph_nxt = next_phase(cw_ph_r[sel]);
            low_coil  = cw_ph_nxt[1:0];
          end else begin
            ccw_ph_nxt = next_phase(ccw_ph_r[sel]);
            low_coil   = 2'd3 - ccw_ph_nxt[1:0];
          end
          res_nxt.coils = ~(COIL_W'(1) << low_coil);
          steps_nxt     = steps_r[sel] - 32'd1;
        end else if (!fin_r[sel]) begin
          // Out of steps: coils stay low, count the finish once.
          fin_nxt               = 1'b1;
          res_nxt.move_finished = 1'b1;
          if (done_r != DONE_MAX) begin
            done_nxt = done_r + 8'd1;
          end
        end
      end
    end

    res_nxt.finished_count = done_nxt;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  // Axis state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        steps_r[i]  <= '0;
        dir_r[i]    <= DIR_CW;
        cw_ph_r[i]  <= PHASE_IDLE;
        ccw_ph_r[i] <= PHASE_IDLE;
        fin_r[i]    <= 1'b0;
      end
      done_r <= '0;
    end else if (advance && in_range) begin
      steps_r[sel]  <= steps_nxt;
      dir_r[sel]    <= dir_nxt;
      cw_ph_r[sel]  <= cw_ph_nxt;
      ccw_ph_r[sel] <= ccw_ph_nxt;
      fin_r[sel]    <= fin_nxt;
      done_r        <= done_nxt;
    end
  end

endmodule

/* rtl/tasms_checker.sv */
// Port-level checks for the stepper move sequencer, bound to the top level.
module tasms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tasms_pkg::out_res_t out_data
);
  import tasms_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Undriven coils read as zero.
  a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.coils_driven |-> out_data.coils == '0)
    else $error("coils non-zero without drive");

  // A stepping pattern is one-cold.
  a_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coils != '0 |->
      out_data.coils_driven && $countones(out_data.coils) == 3)
    else $error("coil pattern is not one-cold");

  // A finish never steps and leaves a non-zero total.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_finished |->
      out_data.coils == '0 && out_data.finished_count != '0)
    else $error("finish with coils driven or zero total");

endmodule

bind three_axis_stepper_move_sequencer tasms_checker u_tasms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/tb_three_axis_stepper_move_sequencer.sv */
// Self-checking testbench for the three-axis stepper move sequencer.
module tb_three_axis_stepper_move_sequencer;
  import tasms_pkg::*;

  // Roughly how many random requests follow the directed opening.
  localparam int RANDOM_REQS = 1800;
  // The slowest legal run has every request waiting out a sender gap and a
  // receiver stall. Allow many times the length of such a run.
  localparam int CYCLE_LIMIT = 200000;
  // A request passes through the input register to the result register.
  // Allow a margin on top before the run is closed.
  localparam int TAIL_CYCLES = 10;

  // One queued request, plus a flag that makes the sender wait until every
  // outstanding result has arrived before offering it.
  typedef struct {
    in_req_t req;
    bit      drain_first;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_res_t  out_data;

  queued_req_t moves_to_send[$];
  out_res_t    coil_results_due[$];

  // Mirror of the sequencer's per-axis state.
  logic [STEPS_W-1:0] steps_left  [AXES];
  logic               axis_dir    [AXES];
  logic [PHASE_W-1:0] cw_ph       [AXES];
  logic [PHASE_W-1:0] ccw_ph      [AXES];
  logic               finish_seen [AXES];
  logic [DONE_W-1:0]  done_total;

  int mismatches = 0;
  int cycle_count = 0;
  int loads_seen = 0, ticks_seen = 0, stray_seen = 0;
  int finishes_seen = 0, cw_steps = 0, ccw_steps = 0, saturated_finishes = 0;

  // Sender burst and gap counters; receiver stall pattern.
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0, mode_left = 0;

  three_axis_stepper_move_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Wrap to phase zero from the last phase or from the no-step-yet marker.
  function automatic logic [PHASE_W-1:0] phase_after(input logic [PHASE_W-1:0] ph);
    phase_after = (ph >= PHASE_LAST) ? '0 : ph + 3'd1;
  endfunction

  // Bump the global finish total, holding it at its ceiling.
  function automatic void note_finish();
    finishes_seen++;
    if (done_total != DONE_MAX) done_total = done_total + 8'd1;
    else saturated_finishes++;
  endfunction

  // Work out the result that one accepted request must give, and update the
  // mirrored state the way the sequencer does.
  function automatic out_res_t next_coil_result(input in_req_t req);
    out_res_t          res;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] count;
    logic [1:0]        low;
    int                a;
    res = '0;
    res.axis_out = req.axis;
    if (req.axis < AXES) begin
      a = int'(req.axis);
      if (req.op == OP_LOAD) begin
        loads_seen++;
        product = PROD_W'(req.move_duration) * PROD_W'(req.move_frequency);
        count = product >> FREQ_FRAC_BITS;
        axis_dir[a] = req.direction;
        if (req.move_frequency == '0 || count == '0) begin
          // Nothing to step: the load ends the move on the spot.
          steps_left[a] = '0;
          finish_seen[a] = 1'b1;
          note_finish();
          res.move_finished = 1'b1;
        end else begin
          steps_left[a] = (count > PROD_W'(32'hFFFF_FFFF)) ? '1 : count[STEPS_W-1:0];
          finish_seen[a] = 1'b0;
        end
      end else begin
        ticks_seen++;
        res.coils_driven = 1'b1;
        if (steps_left[a] != '0) begin
          if (axis_dir[a] == DIR_CW) begin
            cw_ph[a] = phase_after(cw_ph[a]);
            low = cw_ph[a][1:0];
            cw_steps++;
          end else begin
            // Counterclockwise walks the coils from four down to one.
            ccw_ph[a] = phase_after(ccw_ph[a]);
            low = 2'd3 - ccw_ph[a][1:0];
            ccw_steps++;
          end
          res.coils = ~(4'b0001 << low);
          steps_left[a] = steps_left[a] - 32'd1;
        end else if (!finish_seen[a]) begin
          // First idle tick after a move counts the finish, later ones do not.
          finish_seen[a] = 1'b1;
          note_finish();
          res.move_finished = 1'b1;
        end
      end
    end else begin
      stray_seen++;
    end
    res.finished_count = done_total;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic queue_req(input logic op, input logic [1:0] axis, input logic dir,
                           input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                           input bit drain_first);
    queued_req_t q;
    q.req.op = op;
    q.req.axis = axis;
    q.req.direction = dir;
    q.req.move_frequency = freq;
    q.req.move_duration = dur;
    q.drain_first = drain_first;
    moves_to_send.push_back(q);
  endtask

  // Sender: accept, predict, then offer the next request in bursts with gaps.
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        coil_results_due.push_back(next_coil_result(moves_to_send[0].req));
        void'(moves_to_send.pop_front());
      end
      // Hold the offered request until it is taken.
      if (!(in_valid && !in_ready)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (moves_to_send.size() != 0 &&
                     (!moves_to_send[0].drain_first || coil_results_due.size() == 0)) begin
          next_valid = 1'b1;
          in_data <= moves_to_send[0].req;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // End of burst: pick a pause, then a new burst, sometimes a long one.
            gap_left = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Receiver: stall on a pattern that switches between free-running, random
  // and mostly-blocked stretches; check every result taken.
  always @(posedge clk) begin
    out_res_t want;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase

    if (rst_n && out_valid && out_ready) begin
      if (coil_results_due.size() == 0) begin
        report_mismatch("result with nothing due, axis_out", int'(out_data.axis_out), 0);
      end else begin
        want = coil_results_due.pop_front();
        if (out_data.axis_out !== want.axis_out)
          report_mismatch("axis_out", int'(out_data.axis_out), int'(want.axis_out));
        if (out_data.coils !== want.coils)
          report_mismatch("coils", int'(out_data.coils), int'(want.coils));
        if (out_data.coils_driven !== want.coils_driven)
          report_mismatch("coils_driven", int'(out_data.coils_driven),
                          int'(want.coils_driven));
        if (out_data.move_finished !== want.move_finished)
          report_mismatch("move_finished", int'(out_data.move_finished),
                          int'(want.move_finished));
        if (out_data.finished_count !== want.finished_count)
          report_mismatch("finished_count", int'(out_data.finished_count),
                          int'(want.finished_count));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d requests unsent and %0d results outstanding",
               moves_to_send.size(), coil_results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int  pick, ax, tick_ax, steps, n_ticks, k;
    int  dur, freq;
    bit  drain, first_random;
    for (int i = 0; i < AXES; i++) begin
      steps_left[i] = '0;
      axis_dir[i] = DIR_CW;
      cw_ph[i] = PHASE_IDLE;
      ccw_ph[i] = PHASE_IDLE;
      finish_seen[i] = 1'b0;
    end
    done_total = '0;

    // Directed opening.
    // Tick an axis that was never loaded: counts one finish, then no more.
    queue_req(OP_TICK, 2'd0, DIR_CW, '0, '0, 1'b0);
    queue_req(OP_TICK, 2'd0, DIR_CW, '0, '0, 1'b0);
    // Out-of-range axis, as a tick and as a load with every field bit set.
    queue_req(OP_TICK, 2'd3, DIR_CCW, '1, '1, 1'b0);
    queue_req(OP_LOAD, 2'd3, DIR_CCW, '1, '1, 1'b0);
    // Zero frequency with the longest duration finishes at once.
    queue_req(OP_LOAD, 2'd1, DIR_CW, '0, '1, 1'b0);
    // A product below one whole step truncates to no steps at all.
    queue_req(OP_LOAD, 2'd2, DIR_CCW, 24'h000001, 16'h0001, 1'b0);
    // Five clockwise steps from the no-step-yet phase, wrapping, then finish.
    queue_req(OP_LOAD, 2'd0, DIR_CW, 24'h000100, 16'd5, 1'b0);
    repeat (6) queue_req(OP_TICK, 2'd0, DIR_CW, '0, '0, 1'b0);
    // Largest possible move, counterclockwise, stepped through a wrap.
    queue_req(OP_LOAD, 2'd1, DIR_CCW, '1, '1, 1'b0);
    repeat (5) queue_req(OP_TICK, 2'd1, DIR_CW, '1, '1, 1'b0);
    // Alternating bit patterns in the load fields.
    queue_req(OP_LOAD, 2'd2, DIR_CW, 24'hAAAAAA, 16'h5555, 1'b0);
    repeat (2) queue_req(OP_TICK, 2'd2, DIR_CCW, 24'h555555, 16'hAAAA, 1'b0);

    // Random part: mostly short moves ticked to (and past) their end, with
    // stray ticks on other axes, full-range loads, instant finishes and noise.
    first_random = 1'b1;
    while (moves_to_send.size() < RANDOM_REQS + 22) begin
      pick = $urandom_range(0, 99);
      drain = first_random || ($urandom_range(0, 49) == 0);
      first_random = 1'b0;
      if (pick < 55) begin
        ax = $urandom_range(0, AXES - 1);
        dur = $urandom_range(1, 4);
        freq = $urandom_range(1, 3 << FREQ_FRAC_BITS);
        steps = (dur * freq) >> FREQ_FRAC_BITS;
        queue_req(OP_LOAD, 2'(ax), 1'($urandom_range(0, 1)), FREQ_W'(freq), DUR_W'(dur),
                  drain);
        if ($urandom_range(0, 3) != 0) n_ticks = steps + $urandom_range(1, 3);
        else n_ticks = $urandom_range(0, steps);
        for (k = 0; k < n_ticks; k++) begin
          tick_ax = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : ax;
          queue_req(OP_TICK, 2'(tick_ax), 1'($urandom), FREQ_W'($urandom),
                    DUR_W'($urandom), 1'b0);
        end
      end else if (pick < 65) begin
        queue_req(OP_LOAD, 2'($urandom_range(0, 3)), 1'($urandom), FREQ_W'($urandom),
                  DUR_W'($urandom), drain);
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0)
          queue_req(OP_LOAD, 2'($urandom_range(0, 2)), 1'($urandom), '0,
                    DUR_W'($urandom), drain);
        else
          queue_req(OP_LOAD, 2'($urandom_range(0, 2)), 1'($urandom),
                    FREQ_W'($urandom_range(0, 15)), DUR_W'($urandom_range(0, 15)), drain);
      end else begin
        queue_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 1'($urandom),
                  FREQ_W'($urandom), DUR_W'($urandom), drain);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain everything, then give the pipeline time to show any stray result.
    while (moves_to_send.size() != 0 || in_valid || coil_results_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d ticks and %0d out-of-range requests in %0d cycles",
             loads_seen, ticks_seen, stray_seen, cycle_count);
    $display("Stepped %0d cw / %0d ccw, finished %0d moves (%0d past the counter ceiling)",
             cw_steps, ccw_steps, finishes_seen, saturated_finishes);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
